>>> src/seven_segment_value_time_formatter_core_assert.svh
// Assertion macros for the display formatter core.
// SSVTF_ASSERT is disabled while reset is high; SSVTF_ASSERT_ALWAYS is not.
`ifndef SEVEN_SEGMENT_VALUE_TIME_FORMATTER_CORE_ASSERT_SVH
`define SEVEN_SEGMENT_VALUE_TIME_FORMATTER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define SSVTF_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ssvtf check failed");
`define SSVTF_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ssvtf check failed");
`else
`define SSVTF_ASSERT(lbl, clk, rst, prop)
`define SSVTF_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> src/ssvtf_pkg.sv
package ssvtf_pkg;

  localparam int SEG_W = 7;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_VALUE = 2'd1,
    KIND_REL   = 2'd2,
    KIND_TIME  = 2'd3
  } kind_t;

  // value: normal / set (blanked in phase) / blink
  // time:  normal / set minutes / set seconds
  localparam logic [1:0] MODE_NORMAL  = 2'd0;
  localparam logic [1:0] MODE_SET     = 2'd1;
  localparam logic [1:0] MODE_SET_SEC = 2'd2;

  localparam logic [SEG_W-1:0] SEG_BLANK = 7'h00;
  localparam logic [SEG_W-1:0] SEG_L     = 7'h07;
  localparam logic [SEG_W-1:0] SEG_MINUS = 7'h40;
  localparam logic [SEG_W-1:0] SEG_R     = 7'h42;

  localparam logic [15:0] HALF_PERIOD_RESET = 16'd500;
  localparam logic [13:0] VALUE_L0          = 14'd999;

  typedef logic [SEG_W-1:0] seg_t;

  function automatic seg_t seg_digit(input logic [3:0] d);
    seg_t s;
    case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h30;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h79;
      4'd4:    s = 7'h74;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h6F;
      4'd7:    s = 7'h38;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h7D;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

endpackage

>>> src/seven_segment_value_time_formatter_core.sv
// Four-digit seven-segment formatter. Show items (tuser kind 1 value, 2 relative,
// 3 time) latch what the display holds and produce no output; tick items (kind 0,
// one per millisecond) run the blink timer and, when a refresh is due, emit one
// item with four segment patterns and the colon. One input item is taken per
// clock while the input does not stall; the decimal digits are formed from the
// input bus by constant reciprocal multiplies and captured in an input register,
// then the state/format stage loads the result register from it, so a result
// passes the input register and then the result register after its tick is
// accepted. Input stalls only while the result register holds an untaken item and
// the input register is full. cfg_data sets the blink half period (reset 500 ticks); it is always ready.
module seven_segment_value_time_formatter_core
  import ssvtf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // value[13:0], signed_value[24:14], minutes[32:25], seconds[40:33], mode[42:41]
  input  logic [47:0] s_axis_tdata,
  // kind[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // digit3[6:0], digit2[13:7], digit1[20:14], digit0[27:21], colon_on[28]
  output logic [31:0] m_axis_tdata
);

  // ---------------- front: decimal digits ----------------
  logic [13:0] f_value;
  logic [10:0] f_signed;
  logic [7:0]  f_minutes;
  logic [7:0]  f_seconds;
  logic [1:0]  f_mode;
  kind_t       f_kind;
  logic        f_neg;
  logic [11:0] f_mag;
  logic [13:0] conv;
  logic [29:0] prod10;
  logic [26:0] prod100;
  logic [28:0] prod1000;
  logic [10:0] q1;
  logic [7:0]  q2;
  logic [4:0]  q3;
  logic [13:0] r0;
  logic [10:0] r1;
  logic [7:0]  r2;
  logic [3:0]  c3;
  logic [6:0]  mc, sc;
  logic [14:0] mprod, sprod;
  logic [3:0]  mt, st;
  logic [6:0]  mu, su;
  logic [3:0]  f_dig3, f_dig2, f_dig1, f_dig0;

  assign f_value   = s_axis_tdata[13:0];
  assign f_signed  = s_axis_tdata[24:14];
  assign f_minutes = s_axis_tdata[32:25];
  assign f_seconds = s_axis_tdata[40:33];
  assign f_mode    = s_axis_tdata[42:41];
  assign f_kind    = kind_t'(s_axis_tuser);

  assign f_neg = f_signed[10];
  assign f_mag = f_neg ? (12'd2048 - {1'b0, f_signed}) : {1'b0, f_signed};
  assign conv  = (f_kind == KIND_REL) ? {2'b00, f_mag} : f_value;

  // reciprocal multiplies, exact for conv < 16384
  assign prod10   = 30'(conv) * 30'(16'd52429);
  assign prod100  = 27'(conv) * 27'(13'd5243);
  assign prod1000 = 29'(conv) * 29'(15'd16778);
  assign q1 = prod10[29:19];
  assign q2 = prod100[26:19];
  assign q3 = prod1000[28:24];

  assign r0 = conv - {q1, 3'b000} - {2'b00, q1, 1'b0};
  assign r1 = q1 - {q2, 3'b000} - {2'b00, q2, 1'b0};
  assign r2 = q2 - {q3, 3'b000} - {2'b00, q3, 1'b0};
  assign c3 = (q3 >= 5'd10) ? 4'(q3 - 5'd10) : q3[3:0];

  assign mc    = (f_minutes > 8'd99) ? 7'd99 : f_minutes[6:0];
  assign sc    = (f_seconds > 8'd59) ? 7'd59 : f_seconds[6:0];
  assign mprod = 15'(mc) * 15'(8'd205);
  assign sprod = 15'(sc) * 15'(8'd205);
  assign mt    = mprod[14:11];
  assign st    = sprod[14:11];
  assign mu    = mc - {mt, 3'b000} - {2'b00, mt, 1'b0};
  assign su    = sc - {st, 3'b000} - {2'b00, st, 1'b0};

  always_comb begin
    if (f_kind == KIND_TIME) begin
      f_dig3 = mt;
      f_dig2 = mu[3:0];
      f_dig1 = st;
      f_dig0 = su[3:0];
    end else begin
      f_dig3 = c3;
      f_dig2 = r2[3:0];
      f_dig1 = r1[3:0];
      f_dig0 = r0[3:0];
    end
  end

  // ---------------- input register ----------------
  logic       in_valid;
  kind_t      in_kind;
  logic [1:0] in_mode;
  logic [3:0] in_dig3, in_dig2, in_dig1, in_dig0;
  logic       in_ge10, in_ge100, in_ge1000, in_is999, in_neg;
  logic       advance;
  logic       s_accept;

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_accept) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_kind   <= f_kind;
      in_mode   <= f_mode;
      in_dig3   <= f_dig3;
      in_dig2   <= f_dig2;
      in_dig1   <= f_dig1;
      in_dig0   <= f_dig0;
      in_ge10   <= conv >= 14'd10;
      in_ge100  <= conv >= 14'd100;
      in_ge1000 <= conv >= 14'd1000;
      in_is999  <= conv == VALUE_L0;
      in_neg    <= f_neg;
    end
  end

  // ---------------- configuration ----------------
  logic [15:0] blink_half_period;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      blink_half_period <= HALF_PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      blink_half_period <= cfg_data;
    end
  end

  // ---------------- display state ----------------
  seg_t        pat3, pat2, pat1, pat0;
  logic [3:0]  blank_mask;
  logic        colon;
  logic        blink_enabled;
  logic        blink_phase;
  logic [15:0] blink_elapsed;
  logic        refresh_due;

  seg_t        pat3_next, pat2_next, pat1_next, pat0_next;
  logic [3:0]  blank_mask_next;
  logic        colon_next;
  logic        blink_enabled_next;
  logic        blink_phase_next;
  logic [15:0] blink_elapsed_next;
  logic        refresh_due_next;
  logic        emit;
  logic [15:0] elapsed_inc;
  seg_t        sign_seg;
  logic [3:0]  blank_now;

  always_comb begin
    pat3_next          = pat3;
    pat2_next          = pat2;
    pat1_next          = pat1;
    pat0_next          = pat0;
    blank_mask_next    = blank_mask;
    colon_next         = colon;
    blink_enabled_next = blink_enabled;
    blink_phase_next   = blink_phase;
    blink_elapsed_next = blink_elapsed;
    refresh_due_next   = refresh_due;
    emit               = 1'b0;
    elapsed_inc        = (blink_elapsed != 16'hFFFF) ? blink_elapsed + 16'd1 : blink_elapsed;
    sign_seg           = in_neg ? SEG_MINUS : SEG_R;

    if (in_valid && advance) begin
      unique case (in_kind)
        KIND_VALUE: begin
          if (in_is999) begin
            pat3_next = SEG_BLANK;
            pat2_next = SEG_BLANK;
            pat1_next = SEG_L;
            pat0_next = seg_digit(4'd0);
          end else begin
            pat3_next = in_ge1000 ? seg_digit(in_dig3) : SEG_BLANK;
            pat2_next = in_ge100  ? seg_digit(in_dig2) : SEG_BLANK;
            pat1_next = in_ge10   ? seg_digit(in_dig1) : SEG_BLANK;
            pat0_next = seg_digit(in_dig0);
          end
          blank_mask_next    = (in_mode == MODE_SET) ? 4'b1111 : 4'b0000;
          colon_next         = 1'b0;
          blink_enabled_next = in_mode != MODE_NORMAL;
          blink_phase_next   = 1'b0;
          blink_elapsed_next = '0;
          refresh_due_next   = 1'b1;
        end
        KIND_REL: begin
          pat3_next = SEG_BLANK;
          pat2_next = in_ge100 ? seg_digit(in_dig2) : SEG_BLANK;
          pat1_next = in_ge10  ? seg_digit(in_dig1) : SEG_BLANK;
          pat0_next = seg_digit(in_dig0);
          // sign sits just left of the leading digit
          if (!in_ge10) begin
            pat1_next = sign_seg;
          end else if (!in_ge100) begin
            pat2_next = sign_seg;
          end else begin
            pat3_next = sign_seg;
          end
          blank_mask_next    = 4'b0000;
          colon_next         = 1'b0;
          blink_enabled_next = 1'b0;
          refresh_due_next   = 1'b1;
        end
        KIND_TIME: begin
          pat3_next = seg_digit(in_dig3);
          pat2_next = seg_digit(in_dig2);
          pat1_next = seg_digit(in_dig1);
          pat0_next = seg_digit(in_dig0);
          case (in_mode)
            MODE_SET:     blank_mask_next = 4'b1100;
            MODE_SET_SEC: blank_mask_next = 4'b0011;
            default:      blank_mask_next = 4'b0000;
          endcase
          colon_next         = 1'b1;
          blink_enabled_next = in_mode != MODE_NORMAL;
          blink_phase_next   = 1'b0;
          blink_elapsed_next = '0;
          refresh_due_next   = 1'b1;
        end
        KIND_TICK: begin
          if (blink_enabled) begin
            if (elapsed_inc > blink_half_period) begin
              blink_phase_next   = !blink_phase;
              blink_elapsed_next = '0;
              refresh_due_next   = 1'b1;
            end else begin
              blink_elapsed_next = elapsed_inc;
            end
          end
          emit             = refresh_due_next;
          refresh_due_next = 1'b0;
        end
      endcase
    end

    blank_now = blank_mask & {4{blink_phase_next}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pat3          <= SEG_BLANK;
      pat2          <= SEG_BLANK;
      pat1          <= SEG_BLANK;
      pat0          <= seg_digit(4'd0);
      blank_mask    <= 4'b0000;
      colon         <= 1'b0;
      blink_enabled <= 1'b0;
      blink_phase   <= 1'b0;
      blink_elapsed <= '0;
      refresh_due   <= 1'b0;
    end else begin
      pat3          <= pat3_next;
      pat2          <= pat2_next;
      pat1          <= pat1_next;
      pat0          <= pat0_next;
      blank_mask    <= blank_mask_next;
      colon         <= colon_next;
      blink_enabled <= blink_enabled_next;
      blink_phase   <= blink_phase_next;
      blink_elapsed <= blink_elapsed_next;
      refresh_due   <= refresh_due_next;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_axis_tdata <= {3'b000, colon,
                       blank_now[0] ? SEG_BLANK : pat0,
                       blank_now[1] ? SEG_BLANK : pat1,
                       blank_now[2] ? SEG_BLANK : pat2,
                       blank_now[3] ? SEG_BLANK : pat3};
    end
  end

  // ---------------- checks ----------------
`include "seven_segment_value_time_formatter_core_assert.svh"

  `SSVTF_ASSERT(a_stall_needs_full, clk, rst, !s_axis_tready |-> in_valid)
  `SSVTF_ASSERT(a_show_marks_refresh, clk, rst,
    (in_valid && advance && in_kind != KIND_TICK) |=> refresh_due)
  `SSVTF_ASSERT(a_tick_clears_refresh, clk, rst,
    (in_valid && advance && in_kind == KIND_TICK) |=> !refresh_due)
  `SSVTF_ASSERT(a_result_from_tick, clk, rst,
    (m_axis_tvalid && !$past(m_axis_tvalid)) |-> $past(in_valid && in_kind == KIND_TICK))
  `SSVTF_ASSERT_ALWAYS(a_reset_clears_out, clk, rst |=> !m_axis_tvalid)

endmodule

>>> tb/seven_segment_value_time_formatter_core_test.sv
module seven_segment_value_time_formatter_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ssvtf_pkg::*;

  typedef struct packed {
    kind_t       kind;
    logic [13:0] value;
    logic [10:0] signed_value;
    logic [7:0]  minutes;
    logic [7:0]  seconds;
    logic [1:0]  mode;
  } cmd_t;

  typedef struct packed {
    seg_t d3;
    seg_t d2;
    seg_t d1;
    seg_t d0;
    logic colon;
  } frame_t;

  localparam seg_t DIGIT_SEGS [10] = '{7'h3F, 7'h30, 7'h5B, 7'h79, 7'h74,
                                       7'h6D, 7'h6F, 7'h38, 7'h7F, 7'h7D};
  localparam logic [1:0] MODE_BLINK_ONLY = 2'd3;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // value[13:0], signed_value[24:14], minutes[32:25], seconds[40:33], mode[42:41]
  logic [47:0] s_axis_tdata = '0;
  // kind[1:0]
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // digit3[6:0], digit2[13:7], digit1[20:14], digit0[27:21], colon_on[28]
  logic [31:0] m_axis_tdata;

  seven_segment_value_time_formatter_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // display state as the block should hold it
  logic [15:0] half_period  = HALF_PERIOD_RESET;
  kind_t       shown        = KIND_TICK;
  logic [13:0] held_value   = '0;
  logic [10:0] held_signed  = '0;
  logic [7:0]  held_minutes = '0;
  logic [7:0]  held_seconds = '0;
  logic [1:0]  held_mode    = MODE_NORMAL;
  logic        blink_on     = 1'b0;
  logic        phase        = 1'b0;
  logic [15:0] elapsed      = '0;
  logic        refresh      = 1'b0;

  cmd_t   cmd_q[$];
  frame_t pending_frames[$];
  int     bad_frames = 0;
  bit     in_busy = 1'b0;
  int     in_wait = 0;
  int     in_calm = 0;
  int     out_wait = 0;
  int     out_calm = 0;
  frame_t got_frame;
  frame_t want_frame;

  function automatic seg_t place_seg(int unsigned v, int unsigned w);
    if (v < w) return SEG_BLANK;
    return DIGIT_SEGS[(v / w) % 10];
  endfunction

  // most gaps short, a few long, with occasional runs of no gap at all
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic update_display(input cmd_t c);
    seg_t        d[4];
    logic        colon;
    logic [10:0] mag;
    int unsigned v;
    int unsigned m;
    int unsigned s;
    int unsigned pos;
    d = '{SEG_BLANK, SEG_BLANK, SEG_BLANK, SEG_BLANK};
    colon = 1'b0;
    case (c.kind)
      KIND_VALUE, KIND_TIME: begin
        shown = c.kind;
        held_mode = c.mode;
        if (c.kind == KIND_VALUE) begin
          held_value = c.value;
        end else begin
          held_minutes = c.minutes;
          held_seconds = c.seconds;
        end
        blink_on = (c.mode != MODE_NORMAL);
        phase = 1'b0;
        elapsed = '0;
        refresh = 1'b1;
      end
      KIND_REL: begin
        // phase and timer keep running state
        shown = KIND_REL;
        held_signed = c.signed_value;
        blink_on = 1'b0;
        refresh = 1'b1;
      end
      default: begin
        if (blink_on) begin
          if (elapsed != 16'hFFFF) elapsed++;
          if (elapsed > half_period) begin
            phase = !phase;
            elapsed = '0;
            refresh = 1'b1;
          end
        end
        if (refresh) begin
          refresh = 1'b0;
          if (shown == KIND_TICK || shown == KIND_VALUE) begin
            if (!(held_mode == MODE_SET && phase)) begin
              v = 32'(held_value);
              if (held_value == VALUE_L0) begin
                d[1] = SEG_L;
                d[0] = DIGIT_SEGS[0];
              end else begin
                d[3] = place_seg(v, 1000);
                d[2] = place_seg(v, 100);
                d[1] = place_seg(v, 10);
                d[0] = (v == 0) ? DIGIT_SEGS[0] : place_seg(v, 1);
              end
            end
          end else if (shown == KIND_REL) begin
            mag = held_signed[10] ? -held_signed : held_signed;
            v = 32'(mag);
            d[2] = place_seg(v, 100);
            d[1] = place_seg(v, 10);
            d[0] = (v == 0) ? DIGIT_SEGS[0] : place_seg(v, 1);
            pos = (v < 10) ? 1 : (v < 100) ? 2 : 3;
            d[pos] = held_signed[10] ? SEG_MINUS : SEG_R;
          end else begin
            m = (held_minutes > 8'd99) ? 32'd99 : 32'(held_minutes);
            s = (held_seconds > 8'd59) ? 32'd59 : 32'(held_seconds);
            if (!(held_mode == MODE_SET && phase)) begin
              d[3] = DIGIT_SEGS[m / 10];
              d[2] = DIGIT_SEGS[m % 10];
            end
            if (!(held_mode == MODE_SET_SEC && phase)) begin
              d[1] = DIGIT_SEGS[s / 10];
              d[0] = DIGIT_SEGS[s % 10];
            end
            colon = 1'b1;
          end
          pending_frames.push_back('{d[3], d[2], d[1], d[0], colon});
        end
      end
    endcase
  endtask

  task automatic report_bad(input string what, input frame_t want, input frame_t got);
    bad_frames++;
    if (bad_frames <= 10)
      $display("%0t %s: expected %h %h %h %h colon %b, got %h %h %h %h colon %b",
               $realtime, what, want.d3, want.d2, want.d1, want.d0, want.colon,
               got.d3, got.d2, got.d1, got.d0, got.colon);
  endtask

  // sender: holds an item until taken, then waits out a random gap
  always @(negedge clk) begin
    if (!in_busy) begin
      if (in_wait > 0) begin
        in_wait--;
        s_axis_tvalid <= 1'b0;
      end else if (cmd_q.size() != 0) begin
        s_axis_tdata <= {5'b0, cmd_q[0].mode, cmd_q[0].seconds, cmd_q[0].minutes,
                         cmd_q[0].signed_value, cmd_q[0].value};
        s_axis_tuser <= cmd_q[0].kind;
        s_axis_tvalid <= 1'b1;
        in_busy = 1'b1;
        in_wait = pick_gap(in_calm);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      update_display(cmd_q.pop_front());
      in_busy = 1'b0;
    end
  end

  always @(negedge clk) begin
    if (out_wait > 0) begin
      out_wait--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) out_wait = pick_gap(out_calm);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_frame = '{m_axis_tdata[6:0], m_axis_tdata[13:7], m_axis_tdata[20:14],
                    m_axis_tdata[27:21], m_axis_tdata[28]};
      if (pending_frames.size() == 0) begin
        report_bad("unexpected item", '0, got_frame);
      end else begin
        want_frame = pending_frames.pop_front();
        if (got_frame.d3 !== want_frame.d3 || got_frame.d2 !== want_frame.d2 ||
            got_frame.d1 !== want_frame.d1 || got_frame.d0 !== want_frame.d0 ||
            got_frame.colon !== want_frame.colon)
          report_bad("mismatch", want_frame, got_frame);
      end
    end
  end

  // a: value, relative value or minutes; b: seconds. Unused fields get noise.
  task automatic add(input kind_t k, input int a, input int b, input logic [1:0] md);
    cmd_t c;
    c.kind = k;
    c.value = 14'($urandom);
    c.signed_value = 11'($urandom);
    c.minutes = 8'($urandom);
    c.seconds = 8'($urandom);
    c.mode = 2'($urandom);
    case (k)
      KIND_VALUE: begin
        c.value = 14'(a);
        c.mode = md;
      end
      KIND_REL: c.signed_value = 11'(a);
      KIND_TIME: begin
        c.minutes = 8'(a);
        c.seconds = 8'(b);
        c.mode = md;
      end
      default: ;
    endcase
    cmd_q.push_back(c);
  endtask

  // wait until every item is taken and every expected frame has arrived
  task automatic wait_idle();
    while (cmd_q.size() != 0 || in_busy || pending_frames.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_half(input logic [15:0] h);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= h;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    half_period = h;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  int          half_list[] = '{1, 0, 2, 65535, 3, 6, 1, 4};
  int          n;
  int          r;
  int          ticks;
  kind_t       k;
  logic [1:0]  md;
  int          a;
  int          b;

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // nothing due after reset
    add(KIND_TICK, 0, 0, 0);
    add(KIND_VALUE, 0, 0, MODE_NORMAL);      add(KIND_TICK, 0, 0, 0);
    add(KIND_VALUE, 9999, 0, MODE_NORMAL);   add(KIND_TICK, 0, 0, 0);
    add(KIND_VALUE, 999, 0, MODE_SET);       add(KIND_TICK, 0, 0, 0);
    // beyond four decimal digits
    add(KIND_VALUE, 16383, 0, MODE_SET_SEC); add(KIND_TICK, 0, 0, 0);
    add(KIND_VALUE, 7, 0, MODE_BLINK_ONLY);  add(KIND_TICK, 0, 0, 0);
    add(KIND_REL, -999, 0, 0);               add(KIND_TICK, 0, 0, 0);
    add(KIND_REL, 999, 0, 0);                add(KIND_TICK, 0, 0, 0);
    add(KIND_REL, 0, 0, 0);                  add(KIND_TICK, 0, 0, 0);
    // magnitude above 999 keeps the sign on the leftmost digit
    add(KIND_REL, -1024, 0, 0);              add(KIND_TICK, 0, 0, 0);
    add(KIND_REL, 1023, 0, 0);
    add(KIND_REL, -5, 0, 0);                 add(KIND_TICK, 0, 0, 0);
    add(KIND_TIME, 255, 255, MODE_SET);      add(KIND_TICK, 0, 0, 0);
    add(KIND_TIME, 0, 0, MODE_SET_SEC);      add(KIND_TICK, 0, 0, 0);
    add(KIND_TIME, 42, 7, MODE_BLINK_ONLY);  add(KIND_TICK, 0, 0, 0);
    add(KIND_TICK, 0, 0, 0);
    wait_idle();

    foreach (half_list[p]) begin
      write_half(16'(half_list[p]));
      n = 0;
      while (n < 100) begin
        k = kind_t'($urandom_range(1, 3));
        r = $urandom_range(0, 9);
        md = (r < 2) ? MODE_NORMAL : (r < 5) ? MODE_SET : (r < 8) ? MODE_SET_SEC
                                                                 : MODE_BLINK_ONLY;
        r = $urandom_range(0, 9);
        b = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 59);
        if (k == KIND_VALUE)
          a = (r == 0) ? 999 : (r == 1) ? $urandom_range(0, 16383) :
              (r == 2) ? $urandom_range(0, 9) : (r == 3) ? $urandom_range(10, 99) :
              (r == 4) ? $urandom_range(100, 999) : $urandom_range(0, 9999);
        else if (k == KIND_REL)
          a = (r < 2) ? $urandom_range(0, 2047) :
              (r < 4) ? $urandom_range(0, 18) - 9 : $urandom_range(0, 1998) - 999;
        else
          a = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 99);
        add(k, a, b, md);
        ticks = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
        repeat (ticks) add(KIND_TICK, 0, 0, 0);
        n += ticks + 1;
      end
      wait_idle();
    end

    bad_frames += pending_frames.size();
    if (bad_frames == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
